/* rtl/tkst_pkg.sv */
// Package for the top-k score table: state and command codes, the tag
// cleanup function and the reset contents of the table.
// No dependencies.
package tkst_pkg;

  localparam int ScoreW = 32;
  localparam int TagW   = 24;
  localparam int IdxW   = 3;
  localparam int RankW  = 3;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUB,
    ST_INS,
    ST_EMIT
  } state_e;

  // Clears every byte that follows the first zero byte of the tag.
  function automatic logic [TagW-1:0] clean_tag(input logic [TagW-1:0] t);
    logic [TagW-1:0] r;
    r = t;
    if (t[23:16] == 8'h00) begin
      r = '0;
    end else if (t[15:8] == 8'h00) begin
      r = {t[23:16], 16'h0000};
    end
    return r;
  endfunction

  function automatic logic [ScoreW-1:0] reset_score(input int i);
    logic [ScoreW-1:0] r;
    unique case (i)
      0: r = 32'd1000;
      1: r = 32'd500;
      2: r = 32'd250;
      3: r = 32'd100;
      4: r = 32'd50;
      5: r = 32'd25;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [TagW-1:0] reset_tag(input int i);
    logic [TagW-1:0] r;
    unique case (i)
      0: r = 24'h432E53;
      1: r = 24'h4C2E4B;
      2: r = 24'h492E49;
      3: r = 24'h4D2E45;
      4: r = 24'h422E53;
      5: r = 24'h592E21;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [ScoreW-1:0] reset_sum(input int n);
    logic [ScoreW-1:0] s;
    s = '0;
    for (int i = 0; i < n; i++) begin
      s = s + reset_score(i);
    end
    return s;
  endfunction

endpackage

/* rtl/tkst_table.sv */
// Score and tag storage of the top-k score table with one read port and
// a shift-down insert at a given position.
// Depends on tkst_pkg.
module tkst_table #(
  parameter int ENTRIES = 6
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr_i,
  output logic [tkst_pkg::ScoreW-1:0]                 rd_score_o,
  output logic [tkst_pkg::TagW-1:0]                   rd_tag_o,
  input  logic                                        ins_en_i,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] ins_pos_i,
  input  logic [tkst_pkg::ScoreW-1:0]                 ins_score_i,
  input  logic [tkst_pkg::TagW-1:0]                   ins_tag_i
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [tkst_pkg::ScoreW-1:0] score_q [ENTRIES];
  logic [tkst_pkg::TagW-1:0]   tag_q   [ENTRIES];

  for (genvar j = 0; j < ENTRIES; j++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        score_q[j] <= tkst_pkg::reset_score(j);
        tag_q[j]   <= tkst_pkg::reset_tag(j);
      end else if (ins_en_i) begin
        if (IW'(j) == ins_pos_i) begin
          score_q[j] <= ins_score_i;
          tag_q[j]   <= ins_tag_i;
        end else if (IW'(j) > ins_pos_i) begin
          score_q[j] <= score_q[(j > 0) ? j - 1 : 0];
          tag_q[j]   <= tag_q[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  assign rd_score_o = score_q[rd_addr_i];
  assign rd_tag_o   = tag_q[rd_addr_i];

  // The table must stay in descending order at all times.
  for (genvar k = 0; k < ENTRIES - 1; k++) begin : g_sorted
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      score_q[k] >= score_q[k+1])
      else $error("Score table is out of order.");
  end

endmodule

/* rtl/top_k_score_table.sv */
// Top level of the top-k score table: input and output beat handling and
// the sequencer that scans, inserts and keeps the running score sum.
// Depends on tkst_pkg and tkst_table.
//
// The block keeps the best ENTRIES scores in descending order, each with a
// three-character tag. An insert scans the table from the bottom with a single
// comparator, one entry per cycle; if its score is placed, it then drops the
// bottom entry, shifts and writes the new one while one shared adder updates the
// running sum, first subtracting the bottom entry and then adding the new score.
// A read beat skips the scan and goes straight to the output stage. The input
// is not ready while an item is in work, but it takes the next beat while a
// finished result still waits in the output register.
module top_k_score_table #(
  parameter int ENTRIES = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // new_score [31:0], tag_chars [55:32], read_index [58:56], zero [63:59]
  input  logic [63:0] s_axis_tdata,
  // command [0]
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rank [2:0], entry_score [34:3], entry_tag [58:35], score_sum [90:59],
  // zero [95:91]
  output logic [95:0] m_axis_tdata,
  // placed [0]
  output logic [0:0]  m_axis_tuser
);

  localparam int PW = $clog2(ENTRIES + 1);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW = (IW > 3) ? IW : 3;
  localparam int RW = tkst_pkg::RankW;

  tkst_pkg::state_e state_q, state_d;

  tkst_pkg::cmd_e                   cmd_q;
  logic [tkst_pkg::ScoreW-1:0]      new_score_q;
  logic [tkst_pkg::TagW-1:0]        tag_q;
  logic [tkst_pkg::IdxW-1:0]        idx_q;
  logic [PW-1:0]                    p_q, p_d;
  logic [tkst_pkg::ScoreW-1:0]      sum_q, sum_d;

  logic                             m_valid_q, m_valid_d;
  logic                             o_placed_q;
  logic [tkst_pkg::RankW-1:0]       o_rank_q;
  logic [tkst_pkg::ScoreW-1:0]      o_score_q;
  logic [tkst_pkg::TagW-1:0]        o_tag_q;
  logic [tkst_pkg::ScoreW-1:0]      o_sum_q;

  logic [IW-1:0]                    rd_addr;
  logic [tkst_pkg::ScoreW-1:0]      rd_score;
  logic [tkst_pkg::TagW-1:0]        rd_tag;
  logic [PW-1:0]                    p_m1;
  logic [XW-1:0]                    idx_ext;
  logic                             idx_ok;
  logic                             placed;
  logic                             s_acc;
  logic                             out_load;
  logic [tkst_pkg::ScoreW-1:0]      addend;

  assign s_axis_tready = (state_q == tkst_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign p_m1          = p_q - PW'(1);
  assign idx_ext       = XW'(idx_q);
  assign idx_ok        = (32'(idx_q) < 32'(ENTRIES));
  assign placed        = (cmd_q == tkst_pkg::CMD_INSERT) && (p_q != PW'(ENTRIES));
  assign out_load      = (state_q == tkst_pkg::ST_EMIT) && (!m_valid_q || m_axis_tready);
  assign addend        = (state_q == tkst_pkg::ST_SUB) ? (~rd_score + 32'd1) : new_score_q;

  always_comb begin
    unique case (state_q)
      tkst_pkg::ST_SCAN: rd_addr = p_m1[IW-1:0];
      tkst_pkg::ST_SUB:  rd_addr = IW'(ENTRIES - 1);
      default:           rd_addr = idx_ext[IW-1:0];
    endcase
  end

  tkst_table #(
    .ENTRIES(ENTRIES)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (rd_addr),
    .rd_score_o  (rd_score),
    .rd_tag_o    (rd_tag),
    .ins_en_i    (state_q == tkst_pkg::ST_INS),
    .ins_pos_i   (p_q[IW-1:0]),
    .ins_score_i (new_score_q),
    .ins_tag_i   (tag_q)
  );

  always_comb begin
    state_d   = state_q;
    p_d       = p_q;
    sum_d     = sum_q;
    m_valid_d = m_valid_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    unique case (state_q)
      tkst_pkg::ST_IDLE: begin
        if (s_acc) begin
          p_d = PW'(ENTRIES);
          state_d = (tkst_pkg::cmd_e'(s_axis_tuser) == tkst_pkg::CMD_READ) ?
                    tkst_pkg::ST_EMIT : tkst_pkg::ST_SCAN;
        end
      end
      tkst_pkg::ST_SCAN: begin
        if (p_q != '0 && new_score_q >= rd_score) begin
          p_d = p_m1;
        end else if (p_q == PW'(ENTRIES)) begin
          state_d = tkst_pkg::ST_EMIT;
        end else begin
          state_d = tkst_pkg::ST_SUB;
        end
      end
      tkst_pkg::ST_SUB: begin
        sum_d   = sum_q + addend;
        state_d = tkst_pkg::ST_INS;
      end
      tkst_pkg::ST_INS: begin
        sum_d   = sum_q + addend;
        state_d = tkst_pkg::ST_EMIT;
      end
      tkst_pkg::ST_EMIT: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          state_d   = tkst_pkg::ST_IDLE;
        end
      end
      default: state_d = tkst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tkst_pkg::ST_IDLE;
      p_q       <= '0;
      sum_q     <= tkst_pkg::reset_sum(ENTRIES);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      sum_q     <= sum_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q       <= tkst_pkg::cmd_e'(s_axis_tuser);
      new_score_q <= s_axis_tdata[31:0];
      tag_q       <= tkst_pkg::clean_tag(s_axis_tdata[55:32]);
      idx_q       <= s_axis_tdata[58:56];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_placed_q <= placed;
      o_rank_q   <= placed ? RW'(p_q) : '0;
      o_sum_q    <= sum_q;
      if (placed) begin
        o_score_q <= new_score_q;
        o_tag_q   <= tag_q;
      end else if (cmd_q == tkst_pkg::CMD_READ && idx_ok) begin
        o_score_q <= rd_score;
        o_tag_q   <= rd_tag;
      end else begin
        o_score_q <= '0;
        o_tag_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = o_placed_q;
  assign m_axis_tdata  = {5'd0, o_sum_q, o_tag_q, o_score_q, o_rank_q};

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != tkst_pkg::ST_IDLE |-> p_q <= PW'(ENTRIES))
    else $error("Scan position beyond the table.");

  a_ins_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tkst_pkg::ST_INS |-> p_q < PW'(ENTRIES))
    else $error("Insert outside the table.");

  a_sub_then_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tkst_pkg::ST_SUB |=> state_q == tkst_pkg::ST_INS)
    else $error("Sum update was split from its insert.");

endmodule

/* sim/top_k_score_table_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for top_k_score_table: directed and random inserts and
// reads, with a mirrored copy of the ranked table to predict every result beat.
// Depends on tkst_pkg and the top_k_score_table RTL.
module top_k_score_table_tb;

  localparam int NSLOTS    = 6;
  localparam int TAIL      = NSLOTS + 10;
  localparam int LONG_HOLD = 64;
  localparam int NRANDOM   = 1400;

  localparam logic [31:0] BOOT_SCORE [6] = '{32'd1000, 32'd500, 32'd250,
                                              32'd100, 32'd50, 32'd25};
  localparam logic [23:0] BOOT_TAG [6] = '{24'h432E53, 24'h4C2E4B, 24'h492E49,
                                            24'h4D2E45, 24'h422E53, 24'h592E21};

  typedef struct packed {
    logic        placed;
    logic [2:0]  rank;
    logic [31:0] score;
    logic [23:0] tag;
    logic [31:0] sum;
  } reply_t;

  class leaderboard_mirror;
    logic [31:0] slot_score [NSLOTS];
    logic [23:0] slot_tag [NSLOTS];
    reply_t      due_replies [$];
    int          mismatches;

    function new();
      for (int i = 0; i < NSLOTS; i++) begin
        slot_score[i] = (i < 6) ? BOOT_SCORE[i] : '0;
        slot_tag[i]   = (i < 6) ? BOOT_TAG[i] : '0;
      end
      mismatches = 0;
    endfunction

    // A tag ends at its first zero byte, and nothing after it is kept.
    function logic [23:0] trim_tag(logic [23:0] raw);
      logic [23:0] kept;
      logic        live;
      kept = '0;
      live = 1'b1;
      for (int b = 2; b >= 0; b--) begin
        if (raw[8*b +: 8] == 8'h00) live = 1'b0;
        if (live) kept[8*b +: 8] = raw[8*b +: 8];
      end
      return kept;
    endfunction

    function logic [31:0] total();
      logic [31:0] s;
      s = '0;
      for (int i = 0; i < NSLOTS; i++) s = s + slot_score[i];
      return s;
    endfunction

    function void apply_request(tkst_pkg::cmd_e cmd, logic [31:0] score,
                                logic [23:0] raw_tag, logic [2:0] idx);
      reply_t      r;
      int          p;
      logic [23:0] tag;
      r   = '0;
      tag = trim_tag(raw_tag);
      if (cmd == tkst_pkg::CMD_INSERT) begin
        p = NSLOTS;
        while (p > 0 && score >= slot_score[p-1]) p--;
        if (p < NSLOTS) begin
          for (int j = NSLOTS - 1; j > p; j--) begin
            slot_score[j] = slot_score[j-1];
            slot_tag[j]   = slot_tag[j-1];
          end
          slot_score[p] = score;
          slot_tag[p]   = tag;
          r.placed = 1'b1;
          r.rank   = p[2:0];
          r.score  = score;
          r.tag    = tag;
        end
      end else if (idx < NSLOTS) begin
        r.score = slot_score[idx];
        r.tag   = slot_tag[idx];
      end
      r.sum = total();
      due_replies.push_back(r);
    endfunction

    task note_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    task match_reply(reply_t got);
      reply_t want;
      if (due_replies.size() == 0) begin
        note_mismatch("beat with nothing pending", got.sum, '0);
        return;
      end
      want = due_replies.pop_front();
      if (got.placed !== want.placed)
        note_mismatch("placed", 32'(got.placed), 32'(want.placed));
      if (got.rank !== want.rank)
        note_mismatch("rank", 32'(got.rank), 32'(want.rank));
      if (got.score !== want.score) note_mismatch("entry_score", got.score, want.score);
      if (got.tag !== want.tag)
        note_mismatch("entry_tag", 32'(got.tag), 32'(want.tag));
      if (got.sum !== want.sum) note_mismatch("score_sum", got.sum, want.sum);
    endtask

    function int pending();
      return due_replies.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  logic tx_calm;
  int   hold_req;
  leaderboard_mirror board;

  top_k_score_table #(
    .ENTRIES(NSLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL top_k_score_table");
    $finish;
  end

  task automatic send_beat(tkst_pkg::cmd_e cmd, logic [31:0] score, logic [23:0] tag,
                           logic [2:0] idx);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, idx, tag, score};
    s_axis_tuser  = cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    board.apply_request(cmd, score, tag, idx);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [23:0] random_tag();
    logic [23:0] t;
    int          pick;
    t    = 24'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2) t[23:16] = 8'h00;
    else if (pick < 4) t[15:8] = 8'h00;
    else if (pick == 4) t[7:0] = 8'h00;
    return t;
  endfunction

  // Most scores land close to a current entry so that ties and every rank occur.
  function automatic logic [31:0] random_score();
    int pick;
    int k;
    pick = $urandom_range(0, 19);
    k    = $urandom_range(0, NSLOTS - 1);
    if (pick < 8) return board.slot_score[k] + $urandom_range(0, 6) - 3;
    if (pick < 11) return board.slot_score[k];
    if (pick < 15) return $urandom;
    return $urandom_range(0, 2000);
  endfunction

  initial begin
    board         = new();
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tkst_pkg::CMD_INSERT;
    rst_ni        = 1'b0;
    tx_calm       = 1'b0;
    hold_req      = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 8; i++) send_beat(tkst_pkg::CMD_READ, '0, '0, 3'(i));
    send_beat(tkst_pkg::CMD_INSERT, 32'hFFFF_FFFF, 24'hFFFFFF, 3'd7);
    send_beat(tkst_pkg::CMD_INSERT, 32'hFFFF_FFFF, 24'h414243, 3'd0);
    send_beat(tkst_pkg::CMD_INSERT, 32'd0, 24'h585858, 3'd0);
    send_beat(tkst_pkg::CMD_INSERT, 32'd100, 24'h5A005A, 3'd0);
    send_beat(tkst_pkg::CMD_INSERT, 32'd99, 24'h515151, 3'd0);
    send_beat(tkst_pkg::CMD_INSERT, 32'd500, 24'h00FFFF, 3'd0);
    send_beat(tkst_pkg::CMD_INSERT, 32'd1000, 24'h4A4B00, 3'd0);
    for (int i = 0; i < NSLOTS; i++) begin
      send_beat(tkst_pkg::CMD_READ, 32'hFFFF_FFFF, 24'hFFFFFF, 3'(i));
    end
    send_beat(tkst_pkg::CMD_INSERT, 32'hFFFF_FFFE, 24'h4D4D4D, 3'd0);
    send_beat(tkst_pkg::CMD_READ, '0, '0, 3'd7);

    for (int n = 0; n < NRANDOM; n++) begin
      tx_calm = ((n / 128) % 3) == 1;
      if (n == 300 || n == 900) hold_req++;
      if (n == 600 || n == 1100) drain();
      if ($urandom_range(0, 3) == 0) begin
        send_beat(tkst_pkg::CMD_READ, $urandom, random_tag(), 3'($urandom_range(0, 7)));
      end else begin
        send_beat(tkst_pkg::CMD_INSERT, random_score(), random_tag(),
                  3'($urandom_range(0, 7)));
      end
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS top_k_score_table");
    end else begin
      $display("FAIL top_k_score_table");
    end
    $finish;
  end

  initial begin
    reply_t got;
    int     stall;
    int     served;
    int     holds_seen;
    m_axis_tready = 1'b0;
    served        = 0;
    holds_seen    = 0;
    wait (rst_ni);
    forever begin
      if (hold_req != holds_seen) begin
        holds_seen++;
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      stall = (((served / 97) % 3) == 2) ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.placed = m_axis_tuser[0];
      got.rank   = m_axis_tdata[2:0];
      got.score  = m_axis_tdata[34:3];
      got.tag    = m_axis_tdata[58:35];
      got.sum    = m_axis_tdata[90:59];
      board.match_reply(got);
      served++;
    end
  end

endmodule

/* filelist.f */
rtl/tkst_pkg.sv
rtl/tkst_table.sv
rtl/top_k_score_table.sv
sim/top_k_score_table_tb.sv
